// ===== rtl/ils_pkg.sv =====
`timescale 1ns / 1ps

package ils_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CntW     = 5;
  localparam int unsigned DataW    = 32;

  typedef enum logic [2:0] {
    ACT_INSERT     = 3'd0,
    ACT_DELETE     = 3'd1,
    ACT_READ       = 3'd2,
    ACT_PUSH_FRONT = 3'd3,
    ACT_PUSH_BACK  = 3'd4,
    ACT_POP_FRONT  = 3'd5,
    ACT_POP_BACK   = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_e;

  // broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [CntW-1:0]         pos;
    logic signed [DataW-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/indexed_list_store.sv =====
// channel | direction | handshake              | payload
// request | in        | in_valid_i / in_ready_o   | action_i, index_i, value_i
// result  | out       | out_valid_o / out_ready_i | read_value_o, error_o, count_o, is_empty_o
//
// One request per cycle while in_ready_o is high; its result is registered and shows in the cycle after acceptance.
// All cells shift or hold in the same cycle, set by compares against the position.
// Reset clears the count and the result valid flag; cell contents and result fields are not reset.
// in_ready_o drops only while a result waits and out_ready_i is low.
`timescale 1ns / 1ps

module indexed_list_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       action_i,
  input  logic [ils_pkg::CntW-1:0]         index_i,
  input  logic signed [ils_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [ils_pkg::DataW-1:0] read_value_o,
  output logic                             error_o,
  output logic [ils_pkg::CntW-1:0]         count_o,
  output logic                             is_empty_o
);
  import ils_pkg::*;

  localparam logic [CntW-1:0] Cap = CntW'(CAPACITY);

  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q;
  logic signed [DataW-1:0] rv_q, rv_d;
  logic                    err_q, err_d;
  logic [CntW-1:0]         cnt_q;

  cmd_t                    cmd;
  logic                    accept, full, rd;
  logic signed [DataW-1:0] cell_data [CAPACITY];
  logic signed [DataW-1:0] cell_hit  [CAPACITY];
  logic signed [DataW-1:0] hit_or;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == Cap);

  always_comb begin
    cmd       = '0;
    cmd.value = value_i;
    cmd.pos   = index_i;
    rd        = 1'b0;
    err_d     = 1'b0;
    count_d   = count_q;
    case (action_e'(action_i))
      ACT_INSERT: begin
        err_d   = full || (index_i > count_q);
        cmd.ins = !err_d;
      end
      ACT_DELETE: begin
        err_d   = (index_i >= count_q);
        cmd.del = !err_d;
      end
      ACT_READ: begin
        err_d = (index_i >= count_q);
        rd    = !err_d;
      end
      ACT_PUSH_FRONT: begin
        err_d   = full;
        cmd.pos = '0;
        cmd.ins = !err_d;
      end
      ACT_PUSH_BACK: begin
        err_d   = full;
        cmd.pos = count_q;
        cmd.ins = !err_d;
      end
      ACT_POP_FRONT: begin
        err_d   = (count_q == '0);
        cmd.pos = '0;
        cmd.del = !err_d;
        rd      = !err_d;
      end
      ACT_POP_BACK: begin
        err_d   = (count_q == '0);
        cmd.pos = count_q - CntW'(1);
        cmd.del = !err_d;
        rd      = !err_d;
      end
      default: begin
        count_d = '0;
      end
    endcase
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.del) begin
      count_d = count_q - CntW'(1);
    end
    if (!accept) begin
      cmd.ins = 1'b0;
      cmd.del = 1'b0;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DataW-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next = '0;
    end else begin : g_inner
      assign next = cell_data[g+1];
    end
    ils_cell u_cell (
      .clk_i  (clk_i),
      .slot_i (CntW'(g)),
      .cmd_i  (cmd),
      .prev_i (prev),
      .next_i (next),
      .data_o (cell_data[g]),
      .hit_o  (cell_hit[g])
    );
  end

  always_comb begin
    hit_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_or = hit_or | cell_hit[i];
    end
    rv_d = rd ? hit_or : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rv_q  <= rv_d;
      err_q <= err_d;
      cnt_q <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign error_o      = err_q;
  assign count_o      = cnt_q;
  assign is_empty_o   = (cnt_q == '0);

endmodule

// ===== rtl/ils_cell.sv =====
`timescale 1ns / 1ps

module ils_cell (
  input  logic                             clk_i,
  input  logic [ils_pkg::CntW-1:0]         slot_i,
  input  ils_pkg::cmd_t                    cmd_i,
  input  logic signed [ils_pkg::DataW-1:0] prev_i,
  input  logic signed [ils_pkg::DataW-1:0] next_i,
  output logic signed [ils_pkg::DataW-1:0] data_o,
  output logic signed [ils_pkg::DataW-1:0] hit_o
);
  import ils_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic                    at_pos, past_pos;

  assign at_pos   = (slot_i == cmd_i.pos);
  assign past_pos = (slot_i > cmd_i.pos);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (at_pos) begin
        data_d = cmd_i.value;
      end else if (past_pos) begin
        data_d = prev_i;
      end
    end else if (cmd_i.del) begin
      if (at_pos || past_pos) begin
        data_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = at_pos ? data_q : '0;

endmodule

// ===== rtl/ils_checker.sv =====
`timescale 1ns / 1ps

module ils_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [2:0]                       action_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [ils_pkg::DataW-1:0] read_value_o,
  input logic                             error_o,
  input logic [ils_pkg::CntW-1:0]         count_o,
  input logic                             is_empty_o
);
  import ils_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(error_o) && $stable(count_o))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CntW'(CAPACITY)))
    else $error("count above capacity");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> (read_value_o == '0))
    else $error("refused request returned data");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_CLEAR)
      |=> out_valid_o && !error_o && (count_o == '0))
    else $error("clear result wrong");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

// ===== verif/indexed_list_store_test.sv =====
`timescale 1ns / 1ps

module indexed_list_store_test;
  import ils_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [DataW-1:0] cells [CAPACITY];
    int unsigned             count;
  } list_state_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic                    error;
    logic [CntW-1:0]         count;
    logic                    is_empty;
  } list_result_t;

  typedef struct {
    action_e                 action;
    logic [CntW-1:0]         index;
    logic signed [DataW-1:0] value;
    int unsigned             idle_pct;
    int unsigned             stall_pct;
    bit                      drain;
  } list_request_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [2:0]              action_i = ACT_CLEAR;
  logic [CntW-1:0]         index_i = '0;
  logic signed [DataW-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] read_value_o;
  logic                    error_o;
  logic [CntW-1:0]         count_o;
  logic                    is_empty_o;

  list_request_t pending_requests[$];
  list_result_t  expected_results[$];
  list_state_t   plan_state;
  list_state_t   held_state;
  list_request_t current_request;

  int unsigned stall_pct = 0;
  int unsigned cur_idle = 0;
  int unsigned cur_stall = 0;
  bit          cur_drain = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_refused = 0;
  int unsigned n_full_seen = 0;
  int unsigned n_empty_seen = 0;
  int unsigned action_tally [8];
  int unsigned cycle_count = 0;

  indexed_list_store dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .error_o      (error_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void place_value(inout list_state_t st, input int unsigned pos,
                                      input logic signed [DataW-1:0] v);
    int unsigned i;
    for (i = st.count; i > pos; i--) st.cells[i] = st.cells[i-1];
    st.cells[pos] = v;
    st.count++;
  endfunction

  function automatic logic signed [DataW-1:0] take_value(inout list_state_t st,
                                                         input int unsigned pos);
    logic signed [DataW-1:0] v;
    int unsigned i;
    v = st.cells[pos];
    for (i = pos; i + 1 < st.count; i++) st.cells[i] = st.cells[i+1];
    st.count--;
    return v;
  endfunction

  // applies one request to a list and returns its response
  function automatic list_result_t apply_request(inout list_state_t st,
                                                 input list_request_t rq);
    list_result_t res;
    bit full;
    int unsigned idx;
    res = '0;
    full = st.count >= CAPACITY;
    idx = 32'(rq.index);
    case (rq.action)
      ACT_INSERT: begin
        if (full || idx > st.count) res.error = 1'b1;
        else place_value(st, idx, rq.value);
      end
      ACT_DELETE: begin
        if (idx >= st.count) res.error = 1'b1;
        else void'(take_value(st, idx));
      end
      ACT_READ: begin
        if (idx >= st.count) res.error = 1'b1;
        else res.read_value = st.cells[idx];
      end
      ACT_PUSH_FRONT: begin
        if (full) res.error = 1'b1;
        else place_value(st, 0, rq.value);
      end
      ACT_PUSH_BACK: begin
        if (full) res.error = 1'b1;
        else place_value(st, st.count, rq.value);
      end
      ACT_POP_FRONT: begin
        if (st.count == 0) res.error = 1'b1;
        else res.read_value = take_value(st, 0);
      end
      ACT_POP_BACK: begin
        if (st.count == 0) res.error = 1'b1;
        else res.read_value = take_value(st, st.count - 1);
      end
      default: st.count = 0;
    endcase
    res.count = st.count[CntW-1:0];
    res.is_empty = st.count == 0;
    return res;
  endfunction

  task automatic plan_request(input action_e act, input logic [CntW-1:0] idx,
                              input logic signed [DataW-1:0] v);
    list_request_t rq;
    rq.action = act;
    rq.index = idx;
    rq.value = v;
    rq.idle_pct = cur_idle;
    rq.stall_pct = cur_stall;
    rq.drain = cur_drain;
    cur_drain = 1'b0;
    void'(apply_request(plan_state, rq));
    pending_requests.push_back(rq);
  endtask

  function automatic logic signed [DataW-1:0] random_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    list_request_t rq;
    list_result_t  rsp;
    logic          next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      held_state.count = 0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        rsp = apply_request(held_state, current_request);
        expected_results.push_back(rsp);
        n_sent++;
        action_tally[current_request.action]++;
        if (rsp.error) n_refused++;
        if (held_state.count == CAPACITY) n_full_seen++;
        if (rsp.is_empty) n_empty_seen++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_requests.size() != 0) begin
        rq = pending_requests[0];
        if (!(rq.drain && n_results != n_sent) && $urandom_range(0, 99) >= rq.idle_pct) begin
          void'(pending_requests.pop_front());
          current_request = rq;
          action_i <= rq.action;
          index_i <= rq.index;
          value_i <= rq.value;
          stall_pct <= rq.stall_pct;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    list_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result count", DataW'(count_o), '0);
        end else begin
          want = expected_results.pop_front();
          if (read_value_o !== want.read_value)
            report_mismatch("read_value", read_value_o, want.read_value);
          if (error_o !== want.error)
            report_mismatch("error", DataW'(error_o), DataW'(want.error));
          if (count_o !== want.count)
            report_mismatch("count", DataW'(count_o), DataW'(want.count));
          if (is_empty_o !== want.is_empty)
            report_mismatch("is_empty", DataW'(is_empty_o), DataW'(want.is_empty));
          n_results <= n_results + 1;
        end
      end
      out_ready_i <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned k;
    bit          growing;
    action_e     act;
    logic [CntW-1:0] idx;
    int unsigned idle_set [4];
    int unsigned stall_set [4];

    idle_set = '{0, 85, 0, 6};
    stall_set = '{0, 0, 85, 6};
    plan_state.count = 0;

    // empty list, out-of-range positions, field extremes
    cur_drain = 1'b1;
    plan_request(ACT_POP_FRONT, 5'd31, 32'sh7FFF_FFFF);
    plan_request(ACT_POP_BACK, 5'd0, 32'sh8000_0000);
    plan_request(ACT_READ, 5'd0, -1);
    plan_request(ACT_DELETE, 5'd31, '0);
    plan_request(ACT_INSERT, 5'd1, 32'sh1234_5678);
    plan_request(ACT_PUSH_FRONT, 5'd31, 32'sh8000_0000);
    plan_request(ACT_INSERT, 5'd0, 32'sh7FFF_FFFF);
    plan_request(ACT_PUSH_BACK, 5'd0, -1);
    plan_request(ACT_INSERT, 5'd3, '0);
    plan_request(ACT_READ, 5'd4, '0);
    for (k = 0; k < 12; k++) begin
      if (k[0]) plan_request(ACT_PUSH_BACK, 5'd0, random_value());
      else plan_request(ACT_INSERT, CntW'($urandom_range(0, plan_state.count)),
                        random_value());
    end
    // full list
    plan_request(ACT_INSERT, 5'd16, 32'sh0F0F_0F0F);
    plan_request(ACT_PUSH_FRONT, 5'd0, 32'sh0F0F_0F0F);
    plan_request(ACT_PUSH_BACK, 5'd0, 32'sh0F0F_0F0F);
    plan_request(ACT_READ, 5'd15, '0);
    plan_request(ACT_DELETE, 5'd16, '0);
    plan_request(ACT_DELETE, 5'd7, '0);
    plan_request(ACT_POP_BACK, 5'd0, '0);
    plan_request(ACT_POP_FRONT, 5'd0, '0);
    plan_request(ACT_CLEAR, 5'd31, -1);
    plan_request(ACT_POP_BACK, 5'd0, '0);

    growing = 1'b1;
    for (phase = 0; phase < 8; phase++) begin
      cur_idle = idle_set[phase % 4];
      cur_stall = stall_set[phase % 4];
      cur_drain = 1'b1;
      for (n = 0; n < 160; n++) begin
        if (plan_state.count == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
        if (plan_state.count == 0) growing = 1'b1;
        k = $urandom_range(0, 99);
        if (k < 15) begin
          act = action_e'(3'($urandom_range(0, 7)));
          idx = CntW'($urandom_range(0, 31));
        end else begin
          k = $urandom_range(0, 99);
          if (k < 1) act = ACT_CLEAR;
          else if (k < 20) act = ACT_READ;
          else if (($urandom_range(0, 99) < 75) == growing)
            act = ($urandom_range(0, 2) == 0) ? ACT_INSERT
                                              : action_e'(3'($urandom_range(3, 4)));
          else
            act = ($urandom_range(0, 2) == 0) ? ACT_DELETE
                                              : action_e'(3'($urandom_range(5, 6)));
          case (act)
            ACT_INSERT: idx = CntW'($urandom_range(0, plan_state.count));
            ACT_DELETE, ACT_READ:
              idx = plan_state.count == 0 ? CntW'($urandom_range(0, 31))
                                          : CntW'($urandom_range(0, plan_state.count - 1));
            default: idx = CntW'($urandom_range(0, 31));
          endcase
        end
        plan_request(act, idx, random_value());
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || n_results != n_sent)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);

    $display("Ran %0d list requests, %0d refused; list full after %0d, empty after %0d.",
             n_sent, n_refused, n_full_seen, n_empty_seen);
    $display("Mix: insert %0d delete %0d read %0d push %0d/%0d pop %0d/%0d clear %0d",
             action_tally[ACT_INSERT], action_tally[ACT_DELETE], action_tally[ACT_READ],
             action_tally[ACT_PUSH_FRONT], action_tally[ACT_PUSH_BACK],
             action_tally[ACT_POP_FRONT], action_tally[ACT_POP_BACK],
             action_tally[ACT_CLEAR]);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
